/* rtl/irenc_pkg.sv */
// shared types, protocol timing table and code packing for the infrared code encoder
`timescale 1ns / 1ps

package irenc_pkg;

	// code word size and field widths
	localparam int MAX_CODE_BITS = 32;
	localparam int BITS_W        = $clog2(MAX_CODE_BITS + 1);
	localparam int DUR_W         = 14;
	localparam int LIMIT_W       = 10;
	// header pair plus one pair per code bit plus the trailer mark
	localparam int IDX_W         = $clog2(2 * MAX_CODE_BITS + 4);

	// protocol codes
	localparam logic [3:0] PROTO_PD_INV  = 4'd0;
	localparam logic [3:0] PROTO_PD_16   = 4'd1;
	localparam logic [3:0] PROTO_BIPHASE = 4'd2;
	localparam logic [3:0] PROTO_PW_12   = 4'd3;
	localparam logic [3:0] PROTO_PW_15   = 4'd4;
	localparam logic [3:0] PROTO_PD_32   = 4'd5;
	localparam logic [3:0] PROTO_COUNT   = 4'd6;

	// result status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
	localparam logic [1:0] ST_OVERFLOW    = 2'd2;

	typedef enum logic [1:0] {
		KIND_PULSE_DIST,
		KIND_MANCHESTER,
		KIND_PULSE_WIDTH
	} bit_kind_t;

	typedef struct packed {
		logic [DUR_W-1:0] hdr_mark;
		logic [DUR_W-1:0] hdr_space;
		logic [DUR_W-1:0] bmark;
		logic [DUR_W-1:0] sp0;
		logic [DUR_W-1:0] sp1;
		logic [DUR_W-1:0] trail;
		bit_kind_t        kind;
	} timing_t;

	// which result the datapath loads into its output register
	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_HDR,
		EMIT_BIT,
		EMIT_TRAIL,
		EMIT_UNSUP,
		EMIT_OVF
	} emit_t;

	// controller to datapath
	typedef struct packed {
		logic  load;
		emit_t emit;
	} irenc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic unsup;
		logic has_hdr;
		logic has_trail;
		logic fits2;
		logic fits1;
		logic bit_final;
		logic out_free;
	} irenc_stat_t;

	// per-protocol timing in microseconds
	function automatic timing_t proto_timing(input logic [2:0] proto);
		timing_t t;
		t = '{hdr_mark: '0, hdr_space: '0, bmark: '0, sp0: '0, sp1: '0, trail: '0,
			kind: KIND_PULSE_DIST};
		unique case ({1'b0, proto})
			PROTO_PD_INV, PROTO_PD_16: begin
				t.hdr_mark  = 14'd9000;
				t.hdr_space = 14'd4500;
				t.bmark     = 14'd560;
				t.sp0       = 14'd560;
				t.sp1       = 14'd1690;
				t.trail     = 14'd560;
			end
			PROTO_BIPHASE: begin
				t.bmark = 14'd889;
				t.sp0   = 14'd889;
				t.sp1   = 14'd889;
				t.kind  = KIND_MANCHESTER;
			end
			PROTO_PW_12, PROTO_PW_15: begin
				t.hdr_mark  = 14'd2400;
				t.hdr_space = 14'd600;
				t.bmark     = 14'd1200;
				t.sp0       = 14'd600;
				t.sp1       = 14'd600;
				t.kind      = KIND_PULSE_WIDTH;
			end
			PROTO_PD_32: begin
				t.hdr_mark  = 14'd4500;
				t.hdr_space = 14'd4500;
				t.bmark     = 14'd560;
				t.sp0       = 14'd560;
				t.sp1       = 14'd1690;
				t.trail     = 14'd560;
			end
			default: ;
		endcase
		return t;
	endfunction

	// number of code bits sent for a protocol
	function automatic logic [BITS_W-1:0] proto_bits(input logic [2:0] proto);
		logic [BITS_W-1:0] n;
		n = '0;
		unique case ({1'b0, proto})
			PROTO_PD_INV:  n = BITS_W'(32);
			PROTO_PD_16:   n = BITS_W'(24);
			PROTO_BIPHASE: n = BITS_W'(11);
			PROTO_PW_12:   n = BITS_W'(12);
			PROTO_PW_15:   n = BITS_W'(15);
			PROTO_PD_32:   n = BITS_W'(24);
			default:       n = '0;
		endcase
		return n;
	endfunction

	// code word left-aligned so the next bit to send is always the msb
	function automatic logic [MAX_CODE_BITS-1:0] pack_code(
		input logic [2:0]  proto,
		input logic [15:0] dev,
		input logic [7:0]  sub,
		input logic [7:0]  fn
	);
		logic [MAX_CODE_BITS-1:0] c;
		c = '0;
		unique case ({1'b0, proto})
			PROTO_PD_INV:  c = {dev[7:0], sub, fn, ~fn};
			PROTO_PD_16:   c = {dev, fn, 8'd0};
			PROTO_BIPHASE: c = {dev[4:0], fn[5:0], 21'd0};
			PROTO_PW_12:   c = {dev[4:0], fn[6:0], 20'd0};
			PROTO_PW_15:   c = {dev[7:0], fn[6:0], 17'd0};
			PROTO_PD_32:   c = {dev[7:0], sub, fn, 8'd0};
			default:       c = '0;
		endcase
		return c;
	endfunction

endpackage

/* rtl/irenc_ctrl.sv */
// sequencing state machine: header, code bits, trailer and error results
`timescale 1ns / 1ps

module irenc_ctrl import irenc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  irenc_stat_t stat,
	output irenc_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_HDR,
		S_BITS,
		S_TRAIL
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.emit = EMIT_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_HDR;
				end
			end
			S_HDR: begin
				if (stat.out_free) begin
					priority if (stat.unsup) begin
						cmd.emit = EMIT_UNSUP;
						state_d  = S_IDLE;
					end else if (!stat.has_hdr) begin
						state_d = S_BITS;
					end else if (!stat.fits2) begin
						cmd.emit = EMIT_OVF;
						state_d  = S_IDLE;
					end else begin
						cmd.emit = EMIT_HDR;
						state_d  = S_BITS;
					end
				end
			end
			S_BITS: begin
				if (stat.out_free) begin
					priority if (!stat.fits2) begin
						cmd.emit = EMIT_OVF;
						state_d  = S_IDLE;
					end else begin
						cmd.emit = EMIT_BIT;
						if (stat.bit_final) begin
							state_d = stat.has_trail ? S_TRAIL : S_IDLE;
						end
					end
				end
			end
			S_TRAIL: begin
				if (stat.out_free) begin
					cmd.emit = stat.fits1 ? EMIT_TRAIL : EMIT_OVF;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/irenc_dp.sv */
// datapath: code shift register, entry count and output register
`timescale 1ns / 1ps

module irenc_dp import irenc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  irenc_cmd_t         cmd,
	output irenc_stat_t        stat,
	input  logic [LIMIT_W-1:0] limit,
	input  logic [3:0]         protocol,
	input  logic [15:0]        device,
	input  logic [7:0]         subdevice,
	input  logic [7:0]         function_req,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [DUR_W-1:0]   first_us,
	output logic [DUR_W-1:0]   second_us,
	output logic               has_second,
	output logic [1:0]         status,
	output logic               last
);

	logic [MAX_CODE_BITS-1:0] code_q;
	logic [BITS_W-1:0]        bits_q;
	logic [IDX_W-1:0]         idx_q;
	logic [2:0]               proto_q;
	logic                     unsup_q;
	logic                     out_valid_q;
	timing_t                  tim;
	logic [LIMIT_W:0]         idx_ext;
	logic                     cur_bit;
	logic [DUR_W-1:0]         bit_a;
	logic [DUR_W-1:0]         bit_b;

	assign tim     = proto_timing(proto_q);
	assign idx_ext = (LIMIT_W + 1)'(idx_q);
	assign cur_bit = code_q[MAX_CODE_BITS-1];

	// status toward the controller
	assign stat.unsup     = unsup_q;
	assign stat.has_hdr   = (tim.hdr_mark != '0);
	assign stat.has_trail = (tim.trail != '0);
	assign stat.fits2     = (idx_ext + (LIMIT_W + 1)'(2)) <= {1'b0, limit};
	assign stat.fits1     = (idx_ext + (LIMIT_W + 1)'(1)) <= {1'b0, limit};
	assign stat.bit_final = (bits_q == BITS_W'(1));
	assign stat.out_free  = !out_valid_q || out_ready;

	// durations of the current code bit
	always_comb begin
		unique case (tim.kind)
			KIND_MANCHESTER: begin
				bit_a = cur_bit ? tim.sp0 : tim.bmark;
				bit_b = cur_bit ? tim.bmark : tim.sp0;
			end
			KIND_PULSE_WIDTH: begin
				bit_a = cur_bit ? tim.bmark : (tim.bmark >> 1);
				bit_b = tim.sp0;
			end
			default: begin
				bit_a = tim.bmark;
				bit_b = cur_bit ? tim.sp1 : tim.sp0;
			end
		endcase
	end

	// command capture and bit sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q  <= '0;
			idx_q   <= '0;
			proto_q <= '0;
			unsup_q <= 1'b0;
		end else if (cmd.load) begin
			unsup_q <= (protocol >= PROTO_COUNT);
			proto_q <= protocol[2:0];
			bits_q  <= proto_bits(protocol[2:0]);
			idx_q   <= '0;
		end else begin
			unique case (cmd.emit)
				EMIT_HDR: idx_q <= idx_q + IDX_W'(2);
				EMIT_BIT: begin
					idx_q  <= idx_q + IDX_W'(2);
					bits_q <= bits_q - BITS_W'(1);
				end
				EMIT_TRAIL: idx_q <= idx_q + IDX_W'(1);
				default: ;
			endcase
		end
	end

	// code word, msb first
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			code_q <= pack_code(protocol[2:0], device, subdevice, function_req);
		end else if (cmd.emit == EMIT_BIT) begin
			code_q <= {code_q[MAX_CODE_BITS-2:0], 1'b0};
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit != EMIT_NONE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		unique case (cmd.emit)
			EMIT_HDR: begin
				first_us   <= tim.hdr_mark;
				second_us  <= tim.hdr_space;
				has_second <= 1'b1;
				status     <= ST_OK;
				last       <= 1'b0;
			end
			EMIT_BIT: begin
				first_us   <= bit_a;
				second_us  <= bit_b;
				has_second <= 1'b1;
				status     <= ST_OK;
				last       <= stat.bit_final && !stat.has_trail;
			end
			EMIT_TRAIL: begin
				first_us   <= tim.trail;
				second_us  <= '0;
				has_second <= 1'b0;
				status     <= ST_OK;
				last       <= 1'b1;
			end
			EMIT_UNSUP: begin
				first_us   <= '0;
				second_us  <= '0;
				has_second <= 1'b0;
				status     <= ST_UNSUPPORTED;
				last       <= 1'b1;
			end
			EMIT_OVF: begin
				first_us   <= '0;
				second_us  <= '0;
				has_second <= 1'b0;
				status     <= ST_OVERFLOW;
				last       <= 1'b1;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/ir_code_timing_encoder.sv */
// top level of the infrared code timing encoder: config register and submodules
`timescale 1ns / 1ps

// Takes one infrared command per input transfer and emits its mark/space
// durations in microseconds, one result per output transfer: a header pair
// where the protocol has one, one pair per code bit (msb first) and a single
// trailer mark where the protocol has one. The last result of a run has last
// set. Unknown protocols give one unsupported result; a run that would exceed
// output_limit entries (register at address 0, reset 1023) ends with one
// overflow result. The sequencer emits at most one result per cycle and holds
// while the output register is full and not being taken; up to 34 results
// per command. A new command is accepted once the previous run's final
// result has been loaded into the output register.

module ir_code_timing_encoder import irenc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         protocol,
	input  logic [15:0]        device,
	input  logic [7:0]         subdevice,
	input  logic [7:0]         function_req,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [DUR_W-1:0]   first_us,
	output logic [DUR_W-1:0]   second_us,
	output logic               has_second,
	output logic [1:0]         status,
	output logic               last
);

	logic [LIMIT_W-1:0] limit_q;
	irenc_cmd_t         cmd;
	irenc_stat_t        stat;
	logic               ctrl_in_ready;

	assign pready = 1'b1;

	// output_limit register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= {LIMIT_W{1'b1}};
		end else if (psel && penable && pwrite && !paddr[2]) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// register readback
	assign prdata = paddr[2] ? 32'd0 : {{(32 - LIMIT_W){1'b0}}, limit_q};

	assign in_ready = ctrl_in_ready;

	irenc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (ctrl_in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	irenc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.limit        (limit_q),
		.protocol     (protocol),
		.device       (device),
		.subdevice    (subdevice),
		.function_req (function_req),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.first_us     (first_us),
		.second_us    (second_us),
		.has_second   (has_second),
		.status       (status),
		.last         (last)
	);

endmodule
